// File: hdl/obm_pkg.sv
// Package for the order book price level matcher.
// Holds sizes, the controller state type and the command and status structs.
// No dependencies.
package obm_pkg;
	localparam int LEVELS = 64;
	localparam int IDX_BITS = $clog2(LEVELS);
	localparam int CNT_BITS = $clog2(LEVELS + 1);
	localparam int PRICE_BITS = 32;
	localparam int QTY_BITS = 31;
	localparam int TIME_BITS = 48;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MREAD,
		ST_MWAIT,
		ST_MATCH,
		ST_SHIFTL,
		ST_SCAN,
		ST_SWAIT,
		ST_SDEC,
		ST_SHIFTR,
		ST_PLACE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_opp_best;
		logic consume;
		logic shl_step;
		logic shl_done;
		logic scan_start;
		logic scan_rd;
		logic scan_next;
		logic merge;
		logic prep_insert;
		logic shr_step;
		logic place;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic item_zero;
		logic item_last;
		logic opp_empty;
		logic crosses;
		logic full_use;
		logic q_zero;
		logic shl_last;
		logic scan_end;
		logic scan_ahead;
		logic scan_equal;
		logic shr_last;
		logic insert_dropped;
	} sts_t;
endpackage

// File: hdl/obm_datapath.sv
// Datapath of the order book matcher: the two side tables, counts and item registers.
// Depends on obm_pkg. Driven by obm_controller through cmd_t and reports sts_t.
module obm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  obm_pkg::cmd_t                 cmd,
	output obm_pkg::sts_t                 sts,
	input  logic                          side,
	input  logic [obm_pkg::PRICE_BITS-1:0] price,
	input  logic [obm_pkg::QTY_BITS-1:0]   quantity,
	input  logic                          last_of_update,
	input  logic [obm_pkg::TIME_BITS-1:0]  update_time,
	output logic [obm_pkg::TIME_BITS-1:0]  stamp,
	output logic [obm_pkg::PRICE_BITS-1:0] best_bid_price,
	output logic [obm_pkg::QTY_BITS-1:0]   best_bid_qty,
	output logic                          bid_present,
	output logic [obm_pkg::PRICE_BITS-1:0] best_ask_price,
	output logic [obm_pkg::QTY_BITS-1:0]   best_ask_qty,
	output logic                          ask_present,
	output logic                          level_dropped
);
	localparam int PB = obm_pkg::PRICE_BITS;
	localparam int QB = obm_pkg::QTY_BITS;
	localparam int IB = obm_pkg::IDX_BITS;
	localparam int CB = obm_pkg::CNT_BITS;

	logic [PB-1:0] px_mem [2][obm_pkg::LEVELS];
	logic [QB-1:0] qt_mem [2][obm_pkg::LEVELS];
	logic [CB-1:0] cnt_q [2];
	logic drop_q;

	logic side_q, last_q;
	logic [PB-1:0] price_q;
	logic [QB-1:0] qty_q;
	logic [obm_pkg::TIME_BITS-1:0] time_q;
	logic [CB-1:0] ptr_q;
	logic [PB-1:0] rpx_q;
	logic [QB-1:0] rqt_q;
	logic dropped_q;

	logic opp, own;
	logic [QB:0] sum;
	logic [IB-1:0] ptr_ix, ptr_up;

	assign own = side_q;
	assign opp = ~side_q;
	assign ptr_ix = ptr_q[IB-1:0];
	assign ptr_up = IB'(ptr_q + CB'(1));
	assign sum = {1'b0, rqt_q} + {1'b0, qty_q};

	always_comb begin
		sts.item_zero = (qty_q == '0);
		sts.item_last = last_q;
		sts.opp_empty = (cnt_q[opp] == '0);
		sts.crosses = side_q ? (rpx_q >= price_q) : (rpx_q <= price_q);
		sts.full_use = (rqt_q <= qty_q);
		sts.q_zero = (qty_q == '0);
		sts.shl_last = (ptr_q + CB'(1) >= cnt_q[opp]);
		sts.scan_end = (ptr_q >= cnt_q[own]);
		sts.scan_ahead = side_q ? (rpx_q < price_q) : (rpx_q > price_q);
		sts.scan_equal = (rpx_q == price_q);
		sts.shr_last = (ptr_q == rpx_q[CB-1:0]);
		sts.insert_dropped = dropped_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			side_q <= side;
			price_q <= price;
			qty_q <= quantity;
			last_q <= last_of_update;
			time_q <= update_time;
		end
		if (cmd.rd_opp_best) begin
			rpx_q <= px_mem[opp][0];
			rqt_q <= qt_mem[opp][0];
			ptr_q <= '0;
		end
		if (cmd.consume) begin
			if (rqt_q <= qty_q) begin
				qty_q <= qty_q - rqt_q;
			end else begin
				qty_q <= '0;
				qt_mem[opp][0] <= rqt_q - qty_q;
			end
		end
		if (cmd.shl_step) begin
			px_mem[opp][ptr_ix] <= px_mem[opp][ptr_up];
			qt_mem[opp][ptr_ix] <= qt_mem[opp][ptr_up];
			ptr_q <= ptr_q + CB'(1);
		end
		if (cmd.scan_start) begin
			ptr_q <= '0;
		end
		if (cmd.scan_rd) begin
			rpx_q <= px_mem[own][ptr_ix];
			rqt_q <= qt_mem[own][ptr_ix];
		end
		if (cmd.scan_next) begin
			ptr_q <= ptr_q + CB'(1);
		end
		if (cmd.merge) begin
			qt_mem[own][ptr_ix] <= sum[QB] ? {QB{1'b1}} : sum[QB-1:0];
		end
		if (cmd.prep_insert) begin
			rpx_q <= {{(PB-CB){1'b0}}, ptr_q};
			if (cnt_q[own] == CB'(obm_pkg::LEVELS)) begin
				dropped_q <= (ptr_q >= CB'(obm_pkg::LEVELS));
				ptr_q <= CB'(obm_pkg::LEVELS - 1);
			end else begin
				dropped_q <= 1'b0;
				ptr_q <= cnt_q[own];
			end
		end
		if (cmd.shr_step) begin
			px_mem[own][ptr_ix] <= px_mem[own][IB'(ptr_q - CB'(1))];
			qt_mem[own][ptr_ix] <= qt_mem[own][IB'(ptr_q - CB'(1))];
			ptr_q <= ptr_q - CB'(1);
		end
		if (cmd.place) begin
			px_mem[own][ptr_ix] <= price_q;
			qt_mem[own][ptr_ix] <= qty_q;
		end
		if (cmd.emit) begin
			stamp <= time_q;
			best_bid_price <= (cnt_q[0] != '0) ? px_mem[0][0] : '0;
			best_bid_qty <= (cnt_q[0] != '0) ? qt_mem[0][0] : '0;
			best_ask_price <= (cnt_q[1] != '0) ? px_mem[1][0] : '0;
			best_ask_qty <= (cnt_q[1] != '0) ? qt_mem[1][0] : '0;
			bid_present <= (cnt_q[0] != '0);
			ask_present <= (cnt_q[1] != '0);
			level_dropped <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			drop_q <= 1'b0;
		end else begin
			if (cmd.shl_done) begin
				cnt_q[opp] <= cnt_q[opp] - CB'(1);
			end
			if (cmd.prep_insert && cnt_q[own] == CB'(obm_pkg::LEVELS)) begin
				drop_q <= 1'b1;
				if (ptr_q < CB'(obm_pkg::LEVELS)) begin
					cnt_q[own] <= CB'(obm_pkg::LEVELS - 1);
				end
			end
			if (cmd.place) begin
				cnt_q[own] <= cnt_q[own] + CB'(1);
			end
			if (cmd.emit) begin
				drop_q <= 1'b0;
			end
		end
	end
endmodule

// File: hdl/obm_controller.sv
// Controller state machine of the order book matcher.
// Depends on obm_pkg. Drives obm_datapath through cmd_t.
module obm_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  obm_pkg::sts_t sts,
	output obm_pkg::cmd_t cmd
);
	obm_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		out_valid_d = out_valid_q && out_stall;
		in_stall = 1'b1;
		unique case (state_q)
			obm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = obm_pkg::ST_MREAD;
				end
			end
			obm_pkg::ST_MREAD: begin
				if (sts.q_zero || sts.opp_empty) begin
					cmd.scan_start = 1'b1;
					state_d = sts.q_zero ? obm_pkg::ST_EMIT : obm_pkg::ST_SCAN;
				end else begin
					cmd.rd_opp_best = 1'b1;
					state_d = obm_pkg::ST_MATCH;
				end
			end
			obm_pkg::ST_MATCH: begin
				if (!sts.crosses) begin
					cmd.scan_start = 1'b1;
					state_d = obm_pkg::ST_SCAN;
				end else begin
					cmd.consume = 1'b1;
					state_d = sts.full_use ? obm_pkg::ST_SHIFTL : obm_pkg::ST_MREAD;
				end
			end
			obm_pkg::ST_SHIFTL: begin
				if (sts.shl_last) begin
					cmd.shl_done = 1'b1;
					state_d = obm_pkg::ST_MREAD;
				end else begin
					cmd.shl_step = 1'b1;
				end
			end
			obm_pkg::ST_SCAN: begin
				if (sts.scan_end) begin
					cmd.prep_insert = 1'b1;
					state_d = obm_pkg::ST_SHIFTR;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d = obm_pkg::ST_SDEC;
				end
			end
			obm_pkg::ST_SDEC: begin
				if (sts.scan_ahead) begin
					cmd.scan_next = 1'b1;
					state_d = obm_pkg::ST_SCAN;
				end else if (sts.scan_equal) begin
					cmd.merge = 1'b1;
					state_d = obm_pkg::ST_EMIT;
				end else begin
					cmd.prep_insert = 1'b1;
					state_d = obm_pkg::ST_SHIFTR;
				end
			end
			obm_pkg::ST_SHIFTR: begin
				if (sts.insert_dropped) begin
					state_d = obm_pkg::ST_EMIT;
				end else if (sts.shr_last) begin
					cmd.place = 1'b1;
					state_d = obm_pkg::ST_EMIT;
				end else begin
					cmd.shr_step = 1'b1;
				end
			end
			obm_pkg::ST_EMIT: begin
				if (!sts.item_last) begin
					state_d = obm_pkg::ST_IDLE;
				end else if (!(out_valid_q && out_stall)) begin
					cmd.emit = 1'b1;
					out_valid_d = 1'b1;
					state_d = obm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = obm_pkg::ST_IDLE;
			end
		endcase
	end
endmodule

// File: hdl/order_book_price_level_matcher_unit.sv
// Top level of the order book price level matcher.
// Each item is loaded, then uses up levels of the opposite side while its price crosses them,
// removing each level it uses in full and shifting the rest forward. Any quantity left then
// scans its own side and merges into an equal level or rests as a new level, shifting lower ones down.
// Throughput: one item at a time; a new item is taken only once the unit is back in idle, which a
// held result (out_stall) can delay. Reset: asynchronous active low; sides empty.
module order_book_price_level_matcher_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          side,
	input  logic [obm_pkg::PRICE_BITS-1:0] price,
	input  logic [obm_pkg::QTY_BITS-1:0]   quantity,
	input  logic                          last_of_update,
	input  logic [obm_pkg::TIME_BITS-1:0]  update_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [obm_pkg::TIME_BITS-1:0]  stamp,
	output logic [obm_pkg::PRICE_BITS-1:0] best_bid_price,
	output logic [obm_pkg::QTY_BITS-1:0]   best_bid_qty,
	output logic                          bid_present,
	output logic [obm_pkg::PRICE_BITS-1:0] best_ask_price,
	output logic [obm_pkg::QTY_BITS-1:0]   best_ask_qty,
	output logic                          ask_present,
	output logic                          level_dropped
);
	obm_pkg::cmd_t cmd;
	obm_pkg::sts_t sts;

	obm_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	obm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.side(side), .price(price), .quantity(quantity),
		.last_of_update(last_of_update), .update_time(update_time),
		.stamp(stamp), .best_bid_price(best_bid_price), .best_bid_qty(best_bid_qty),
		.bid_present(bid_present), .best_ask_price(best_ask_price),
		.best_ask_qty(best_ask_qty), .ask_present(ask_present),
		.level_dropped(level_dropped)
	);
endmodule

// File: hdl/obm_checker.sv
// Port checker for the order book matcher, bound to the top level.
// Depends on obm_pkg and the top level's ports only.
module obm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic bid_present,
	input logic ask_present,
	input logic [obm_pkg::PRICE_BITS-1:0] best_bid_price,
	input logic [obm_pkg::PRICE_BITS-1:0] best_ask_price
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");
	a_no_accept_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second item taken while busy");
	a_bid_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bid_present |-> best_bid_price == '0) else $error("bid price without level");
	a_ask_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ask_present |-> best_ask_price == '0) else $error("ask price without level");
	a_uncrossed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bid_present && ask_present |-> best_bid_price < best_ask_price)
		else $error("book left crossed");
endmodule

bind order_book_price_level_matcher_unit obm_checker u_obm_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the order book price level matcher unit.
// Predicts best-of-book results from its own copy of both price tables.
// Depends on obm_pkg and order_book_price_level_matcher_unit.
`timescale 1ns / 1ps

module testbench;
	localparam int LEVELS = obm_pkg::LEVELS;
	localparam int PRICE_BITS = obm_pkg::PRICE_BITS;
	localparam int QTY_BITS = obm_pkg::QTY_BITS;
	localparam int TIME_BITS = obm_pkg::TIME_BITS;

	typedef struct packed {
		logic [TIME_BITS-1:0] stamp;
		logic [PRICE_BITS-1:0] bid_px;
		logic [QTY_BITS-1:0] bid_q;
		logic bid_on;
		logic [PRICE_BITS-1:0] ask_px;
		logic [QTY_BITS-1:0] ask_q;
		logic ask_on;
		logic dropped;
	} top_of_book_t;

	localparam logic BUY = 1'b0;
	localparam logic SELL = 1'b1;
	localparam logic [QTY_BITS-1:0] QMAX = '1;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic side = 0;
	logic [PRICE_BITS-1:0] price = 0;
	logic [QTY_BITS-1:0] quantity = 0;
	logic last_of_update = 0;
	logic [TIME_BITS-1:0] update_time = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [TIME_BITS-1:0] stamp;
	logic [PRICE_BITS-1:0] best_bid_price;
	logic [QTY_BITS-1:0] best_bid_qty;
	logic bid_present;
	logic [PRICE_BITS-1:0] best_ask_price;
	logic [QTY_BITS-1:0] best_ask_qty;
	logic ask_present;
	logic level_dropped;

	order_book_price_level_matcher_unit dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	logic [PRICE_BITS-1:0] book_px[2][LEVELS];
	logic [QTY_BITS-1:0] book_q[2][LEVELS];
	int book_n[2];
	bit drop_pending;
	top_of_book_t pending_books[$];
	int errors = 0;
	longint cycles = 0;

	function automatic bit ahead(logic s, logic [PRICE_BITS-1:0] a, logic [PRICE_BITS-1:0] b);
		return s == BUY ? a > b : a < b;
	endfunction

	function automatic void pop_best(int s);
		for (int i = 0; i + 1 < book_n[s]; i++) begin
			book_px[s][i] = book_px[s][i + 1];
			book_q[s][i] = book_q[s][i + 1];
		end
		book_n[s]--;
	endfunction

	function automatic void rest(int s, logic [PRICE_BITS-1:0] p, logic [QTY_BITS-1:0] q);
		int pos = 0;
		logic [QTY_BITS:0] sum;
		while (pos < book_n[s] && ahead(s, book_px[s][pos], p)) pos++;
		if (pos < book_n[s] && book_px[s][pos] == p) begin
			sum = book_q[s][pos] + q;
			book_q[s][pos] = sum > QMAX ? QMAX : sum[QTY_BITS-1:0];
			return;
		end
		if (book_n[s] >= LEVELS) begin
			drop_pending = 1;
			if (pos >= LEVELS) return;
			book_n[s] = LEVELS - 1;
		end
		for (int i = book_n[s]; i > pos; i--) begin
			book_px[s][i] = book_px[s][i - 1];
			book_q[s][i] = book_q[s][i - 1];
		end
		book_px[s][pos] = p;
		book_q[s][pos] = q;
		book_n[s]++;
	endfunction

	function automatic void apply_level(logic s, logic [PRICE_BITS-1:0] p,
			logic [QTY_BITS-1:0] q, logic last, logic [TIME_BITS-1:0] t);
		int o = s == BUY ? 1 : 0;
		top_of_book_t r;
		while (q != 0 && book_n[o] > 0) begin
			if (s == BUY ? book_px[o][0] > p : book_px[o][0] < p) break;
			if (book_q[o][0] <= q) begin
				q -= book_q[o][0];
				pop_best(o);
			end else begin
				book_q[o][0] -= q;
				q = 0;
			end
		end
		if (q != 0) rest(s, p, q);
		if (!last) return;
		r = '0;
		r.stamp = t;
		if (book_n[0] > 0) begin
			r.bid_px = book_px[0][0];
			r.bid_q = book_q[0][0];
			r.bid_on = 1;
		end
		if (book_n[1] > 0) begin
			r.ask_px = book_px[1][0];
			r.ask_q = book_q[1][0];
			r.ask_on = 1;
		end
		r.dropped = drop_pending;
		drop_pending = 0;
		pending_books.push_back(r);
	endfunction

	int max_gap = 17;
	int max_stall = 17;

	task automatic send(logic s, logic [PRICE_BITS-1:0] p, logic [QTY_BITS-1:0] q,
			logic last, logic [TIME_BITS-1:0] t);
		int gap;
		gap = $urandom_range(max_gap);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		side <= s;
		price <= p;
		quantity <= q;
		last_of_update <= last;
		update_time <= t;
		do @(posedge clk); while (in_stall);
		apply_level(s, p, q, last, t);
		@(negedge clk);
	endtask

	function automatic logic [TIME_BITS-1:0] rnd_time();
		return TIME_BITS'({$urandom, $urandom});
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (pending_books.size() != 0) @(negedge clk);
		repeat (4 * LEVELS + 20) @(negedge clk);
	endtask

	int out_wait = 0;
	bit out_armed = 0;

	always @(negedge clk) begin
		if (out_valid && !out_armed) begin
			out_armed = 1;
			out_wait = $urandom_range(max_stall);
		end
		if (out_armed && out_wait > 0) begin
			out_stall <= 1;
			out_wait--;
		end else begin
			out_stall <= 0;
			out_armed = 0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && out_valid && !out_stall) begin
			top_of_book_t e;
			if (pending_books.size() == 0) begin
				$error("result with nothing expected, stamp %h", stamp);
				errors++;
			end else begin
				e = pending_books.pop_front();
				if (stamp !== e.stamp) begin
					$error("stamp exp %h got %h", e.stamp, stamp); errors++;
				end
				if (best_bid_price !== e.bid_px) begin
					$error("best_bid_price exp %h got %h", e.bid_px, best_bid_price); errors++;
				end
				if (best_bid_qty !== e.bid_q) begin
					$error("best_bid_qty exp %h got %h", e.bid_q, best_bid_qty); errors++;
				end
				if (bid_present !== e.bid_on) begin
					$error("bid_present exp %b got %b", e.bid_on, bid_present); errors++;
				end
				if (best_ask_price !== e.ask_px) begin
					$error("best_ask_price exp %h got %h", e.ask_px, best_ask_price); errors++;
				end
				if (best_ask_qty !== e.ask_q) begin
					$error("best_ask_qty exp %h got %h", e.ask_q, best_ask_qty); errors++;
				end
				if (ask_present !== e.ask_on) begin
					$error("ask_present exp %b got %b", e.ask_on, ask_present); errors++;
				end
				if (level_dropped !== e.dropped) begin
					$error("level_dropped exp %b got %b", e.dropped, level_dropped); errors++;
				end
			end
		end
		if (cycles > 25000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		send(BUY, 0, 5, 1, 0);
		send(SELL, '1, QMAX, 1, '1);
		send(BUY, 100, 0, 1, 1);
		send(BUY, 100, QMAX, 0, 2);
		send(BUY, 100, 7, 1, 3);
		send(SELL, 90, 10, 1, 4);
		send(SELL, 100, QMAX - 10, 1, 5);
		send(SELL, 200, 30, 0, 6);
		send(SELL, 150, 20, 1, 7);
		send(BUY, 160, 20, 1, 8);
		send(BUY, 250, 50, 1, 9);
		send(SELL, 0, 100, 1, 10);
		send(BUY, '1, 1, 1, 11);
		send(SELL, '1, 1, 1, 12);
		drain();
	endtask

	task automatic test_full_table();
		for (int i = 0; i < LEVELS + 3; i++)
			send(BUY, 1000 + i, 1, i == LEVELS + 2, i);
		send(BUY, 5, 3, 1, 100);
		send(BUY, 5000, 3, 1, 101);
		send(BUY, 1020, 3, 1, 102);
		for (int i = 0; i < LEVELS + 2; i++)
			send(SELL, 9000 - i, 2, i % 9 == 0, 200 + i);
		send(SELL, 20000, 2, 1, 300);
		send(SELL, 0, QMAX, 1, 301);
		drain();
	endtask

	task automatic test_random(int count);
		logic [PRICE_BITS-1:0] mid, p;
		logic [QTY_BITS-1:0] q;
		int kind;
		mid = 1000000;
		for (int i = 0; i < count; i++) begin
			if (i % 300 == 0) begin
				max_gap = $urandom_range(2) == 0 ? 0 : 17;
				max_stall = $urandom_range(2) == 0 ? 0 : 17;
			end
			kind = $urandom_range(99);
			if (kind < 80) p = mid - 40 + $urandom_range(80);
			else p = {$urandom};
			if (kind < 3) q = 0;
			else if (kind < 8) q = QMAX - QTY_BITS'($urandom_range(3));
			else if (kind < 15) q = QTY_BITS'($urandom);
			else q = QTY_BITS'(1 + $urandom_range(60));
			send(1'($urandom_range(1)), p, q, $urandom_range(3) == 0, rnd_time());
			if (i == count / 2) drain();
		end
		max_gap = 17;
		max_stall = 17;
		drain();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_full_table();
		test_random(1700);
		if (errors == 0 && pending_books.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// File: order_book_price_level_matcher_unit.f
hdl/obm_pkg.sv
hdl/obm_datapath.sv
hdl/obm_controller.sv
hdl/order_book_price_level_matcher_unit.sv
hdl/obm_checker.sv
bench/testbench.sv
